@@ src/gps_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gps_pkg: shared types and constants of the gauge pointer smoother
// Configuration layout, controller commands and state, datapath widths.
// ----------------------------------------------------------------------------
package gps_pkg;

  // Distance beyond which the pointer moves at the fast rate
  parameter int FAST_BAND = 20;

  // Datapath widths
  localparam int DATA_W  = 16;  // fields and registers
  localparam int FILT_W  = 20;  // smoothed speed, 4 extra fraction bits
  localparam int DIST_W  = 17;  // raw target minus position
  localparam int PROD_W  = 36;  // speed times span magnitude
  localparam int NUM_W   = 38;  // 2*product + full scale
  localparam int DEN_W   = 21;  // 2*full scale
  localparam int QUO_W   = 17;  // rounded quotient
  localparam int CNT_W   = 5;   // divider step counter
  localparam int DIV_STEPS = QUO_W;

  localparam logic signed [DIST_W-1:0] BAND_S = DIST_W'(FAST_BAND);

  // APB register indexes (byte address = 4*index)
  localparam int ADDR_W = 5;
  localparam logic [2:0] REG_MAX_SPEED   = 3'd0;
  localparam logic [2:0] REG_MIN_STEP    = 3'd1;
  localparam logic [2:0] REG_MAX_STEP    = 3'd2;
  localparam logic [2:0] REG_NORMAL_RATE = 3'd3;
  localparam logic [2:0] REG_FAST_RATE   = 3'd4;

  typedef struct packed {
    logic        [DATA_W-1:0] max_speed;
    logic signed [DATA_W-1:0] min_step;
    logic signed [DATA_W-1:0] max_step;
    logic        [DATA_W-1:0] normal_rate;
    logic        [DATA_W-1:0] fast_rate;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DINIT,
    ST_DIV,
    ST_FILT,
    ST_DONE
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;      // capture input word
    logic mul;       // form speed times span
    logic mul_sel;   // 0: clamped sample, 1: smoothed speed
    logic div_init;  // set up the divider
    logic div_step;  // one quotient bit
    logic filt;      // flags and filter update
    logic out_load;  // load result registers
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_last;
  } status_t;

endpackage

@@ src/gps_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gps_ctrl: sequencer of the gauge pointer smoother
// Steps one word through two map passes and owns both handshakes.
// ----------------------------------------------------------------------------
module gps_ctrl import gps_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;
  logic   pass_q, pass_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_MUL;
      ST_MUL:   state_d = ST_DINIT;
      ST_DINIT: state_d = ST_DIV;
      ST_DIV:   if (status_i.div_last) state_d = pass_q ? ST_DONE : ST_FILT;
      ST_FILT:  state_d = ST_MUL;
      ST_DONE:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o          = '0;
    cmd_o.mul_sel  = pass_q;
    in_stall_o     = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      ST_MUL:   cmd_o.mul      = 1'b1;
      ST_DINIT: cmd_o.div_init = 1'b1;
      ST_DIV:   cmd_o.div_step = 1'b1;
      ST_FILT:  cmd_o.filt     = 1'b1;
      ST_DONE:  cmd_o.out_load = out_free;
      default:  cmd_o          = '0;
    endcase
  end

  // Pass and result-valid bookkeeping
  always_comb begin
    pass_d = pass_q;
    if (cmd_o.load) pass_d = 1'b0;
    else if (cmd_o.filt) pass_d = 1'b1;

    out_valid_d = out_valid_q;
    if (cmd_o.out_load) out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pass_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pass_q      <= pass_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ src/gps_dpath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gps_dpath: datapath of the gauge pointer smoother
// Clamp, span multiplier, restoring divider, smoothing filter, result regs.
// ----------------------------------------------------------------------------
module gps_dpath import gps_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cfg_t                     cfg_i,
  input  cmd_t                     cmd_i,
  output status_t                  status_o,
  input  logic signed [DATA_W-1:0] speed_sample_i,
  input  logic                     sample_invalid_i,
  input  logic signed [DATA_W-1:0] pointer_position_i,
  output logic signed [DATA_W-1:0] target_step_o,
  output logic        [DATA_W-1:0] step_rate_o,
  output logic                     drop_flag_o,
  output logic                     rise_flag_o,
  output logic        [DATA_W-1:0] smoothed_speed_o
);

  // Captured input word
  logic        [DATA_W-1:0] clamped_q;
  logic signed [DATA_W-1:0] pos_q;
  logic        [DATA_W-1:0] clamped_d;

  // Filter state
  logic [FILT_W-1:0] filt_q, filt_d;
  logic              drop_q, rise_q;

  // Multiplier and divider
  logic [PROD_W-1:0] prod_q;
  logic [FILT_W-1:0] full_q;
  logic              neg_q;
  logic [DEN_W:0]    rem_q;
  logic [QUO_W-1:0]  nlow_q;
  logic [QUO_W-1:0]  quo_q;
  logic [DEN_W-1:0]  den_q;
  logic [CNT_W-1:0]  cnt_q;

  // Input clamp: invalid or negative is zero, cap at full scale
  always_comb begin
    if (sample_invalid_i || speed_sample_i[DATA_W-1]) clamped_d = '0;
    else if ($unsigned(speed_sample_i) > cfg_i.max_speed) clamped_d = cfg_i.max_speed;
    else clamped_d = $unsigned(speed_sample_i);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      clamped_q <= clamped_d;
      pos_q     <= pointer_position_i;
    end
  end

  // Span and multiplier operands
  logic signed [DIST_W-1:0] span;
  logic        [DIST_W-1:0] span_abs;
  logic        [FILT_W-1:0] full_x16;
  logic        [FILT_W-1:0] mul_v;
  logic        [FILT_W-1:0] mul_full;

  assign span     = {cfg_i.max_step[DATA_W-1], cfg_i.max_step}
                  - {cfg_i.min_step[DATA_W-1], cfg_i.min_step};
  assign span_abs = span[DIST_W-1] ? -span : span;
  assign full_x16 = {cfg_i.max_speed, 4'b0000};

  always_comb begin
    if (cmd_i.mul_sel) begin
      mul_full = full_x16;
      mul_v    = (filt_q > full_x16) ? full_x16 : filt_q;
    end else begin
      mul_full = {4'b0000, cfg_i.max_speed};
      mul_v    = {4'b0000, clamped_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q <= mul_v * span_abs[DATA_W-1:0];
      full_q <= mul_full;
      neg_q  <= span[DIST_W-1];
    end
  end

  // Rounded division: (2*prod + full) / (2*full), one quotient bit a cycle
  logic [NUM_W-1:0] num;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             fits;

  assign num   = {1'b0, prod_q, 1'b0} + {{(NUM_W-FILT_W){1'b0}}, full_q};
  assign trial = {rem_q[DEN_W-1:0], nlow_q[QUO_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = !diff[DEN_W];

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      rem_q  <= {1'b0, num[NUM_W-1:QUO_W]};
      nlow_q <= num[QUO_W-1:0];
      den_q  <= {full_q, 1'b0};
      quo_q  <= '0;
    end else if (cmd_i.div_step) begin
      rem_q  <= fits ? diff : trial;
      nlow_q <= {nlow_q[QUO_W-2:0], 1'b0};
      quo_q  <= {quo_q[QUO_W-2:0], fits};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= '0;
    else if (cmd_i.div_init) cnt_q <= '0;
    else if (cmd_i.div_step) cnt_q <= cnt_q + 1'b1;
  end

  assign status_o.div_last = (cnt_q == CNT_W'(DIV_STEPS - 1));

  // Quotient to step position; zero full scale pins to min_step
  logic signed [QUO_W:0]    quo_s;
  logic signed [QUO_W+0:0]  mapped_w;
  logic signed [DATA_W-1:0] mapped;

  assign quo_s    = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
  assign mapped_w = {{(QUO_W+1-DATA_W){cfg_i.min_step[DATA_W-1]}}, cfg_i.min_step} + quo_s;
  assign mapped   = (cfg_i.max_speed == '0) ? cfg_i.min_step : mapped_w[DATA_W-1:0];

  // Band check and quarter-step filter
  logic signed [DIST_W-1:0] pos_gap;
  logic                     drop_d, rise_d;
  logic        [FILT_W-1:0] c16;
  logic signed [FILT_W:0]   delta;
  logic        [FILT_W:0]   delta_abs;
  logic        [FILT_W:0]   mag;

  assign pos_gap = {mapped[DATA_W-1], mapped} - {pos_q[DATA_W-1], pos_q};
  assign drop_d  = pos_gap < -BAND_S;
  assign rise_d  = pos_gap > BAND_S;

  assign c16       = {clamped_q, 4'b0000};
  assign delta     = $signed({1'b0, c16}) - $signed({1'b0, filt_q});
  assign delta_abs = delta[FILT_W] ? -delta : delta;
  assign mag       = (delta_abs + (FILT_W+1)'(2)) >> 2;

  always_comb begin
    if (drop_d) filt_d = c16;
    else if (delta[FILT_W]) filt_d = filt_q - mag[FILT_W-1:0];
    else filt_d = filt_q + mag[FILT_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) filt_q <= '0;
    else if (cmd_i.filt) filt_q <= filt_d;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.filt) begin
      drop_q <= drop_d;
      rise_q <= rise_d;
    end
  end

  // Result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      target_step_o    <= mapped;
      step_rate_o      <= (drop_q || rise_q) ? cfg_i.fast_rate : cfg_i.normal_rate;
      drop_flag_o      <= drop_q;
      rise_flag_o      <= rise_q;
      smoothed_speed_o <= filt_q[FILT_W-1:4];
    end
  end

endmodule

@@ src/gauge_pointer_smoother_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gauge_pointer_smoother_core: speed gauge pointer smoother
// APB register file, sequencer and datapath of the smoothing filter.
// ----------------------------------------------------------------------------
// Each accepted word (speed sample, invalid flag, pointer position) yields one
// result word: two span multiplies and two restoring divisions by the
// full-scale speed run one after the other on a shared divider. A new word
// is accepted the cycle after the result is loaded into the output register;
// no new word is taken while one is being worked on, and a stalled output
// holds the finished result back. Registers sit at byte
// addresses 0, 4, 8, 12, 16 (max_speed, min_step, max_step, normal_rate,
// fast_rate); write them only while the block is idle.
module gauge_pointer_smoother_core import gps_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // APB configuration port
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_W-1:0]        paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  // Input word
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [DATA_W-1:0] speed_sample_i,
  input  logic                     sample_invalid_i,
  input  logic signed [DATA_W-1:0] pointer_position_i,
  // Result word
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [DATA_W-1:0] target_step_o,
  output logic        [DATA_W-1:0] step_rate_o,
  output logic                     drop_flag_o,
  output logic                     rise_flag_o,
  output logic        [DATA_W-1:0] smoothed_speed_o
);

  cfg_t    cfg_q;
  cmd_t    cmd;
  status_t status;
  logic    wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[ADDR_W-1:2];

  // Register writes; unknown indexes are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_speed   <= 16'd3200;
      cfg_q.min_step    <= 16'sd0;
      cfg_q.max_step    <= 16'sd3000;
      cfg_q.normal_rate <= 16'd800;
      cfg_q.fast_rate   <= 16'd3000;
    end else if (wr_en) begin
      case (reg_idx)
        REG_MAX_SPEED:   cfg_q.max_speed   <= pwdata[DATA_W-1:0];
        REG_MIN_STEP:    cfg_q.min_step    <= pwdata[DATA_W-1:0];
        REG_MAX_STEP:    cfg_q.max_step    <= pwdata[DATA_W-1:0];
        REG_NORMAL_RATE: cfg_q.normal_rate <= pwdata[DATA_W-1:0];
        REG_FAST_RATE:   cfg_q.fast_rate   <= pwdata[DATA_W-1:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    case (reg_idx)
      REG_MAX_SPEED:   prdata = {16'b0, cfg_q.max_speed};
      REG_MIN_STEP:    prdata = {16'b0, cfg_q.min_step};
      REG_MAX_STEP:    prdata = {16'b0, cfg_q.max_step};
      REG_NORMAL_RATE: prdata = {16'b0, cfg_q.normal_rate};
      REG_FAST_RATE:   prdata = {16'b0, cfg_q.fast_rate};
      default:         prdata = '0;
    endcase
  end

  gps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  gps_dpath u_dpath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg_q),
    .cmd_i              (cmd),
    .status_o           (status),
    .speed_sample_i     (speed_sample_i),
    .sample_invalid_i   (sample_invalid_i),
    .pointer_position_i (pointer_position_i),
    .target_step_o      (target_step_o),
    .step_rate_o        (step_rate_o),
    .drop_flag_o        (drop_flag_o),
    .rise_flag_o        (rise_flag_o),
    .smoothed_speed_o   (smoothed_speed_o)
  );

`ifndef NO_ASSERTIONS
  // Busy right after taking a word
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("accepted a word but did not go busy");

  // A held result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> !(out_valid_o && out_stall_i))
    else $error("result register loaded while a stalled result waits");

  // Drop and rise exclude each other
  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(drop_flag_o && rise_flag_o))
    else $error("drop and rise flags both set");

  // Rate follows the flags
  a_rate_choice: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (step_rate_o == ((drop_flag_o || rise_flag_o) ?
                                     cfg_q.fast_rate : cfg_q.normal_rate)))
    else $error("step rate does not match flags");
`endif

endmodule
